/* hdl/xml_encoding_sniffer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the encoding sniffer
// Implication checks on the rising clock edge, masked during reset.
// ----------------------------------------------------------------------------
`ifndef XML_ENCODING_SNIFFER_MACROS_SVH
`define XML_ENCODING_SNIFFER_MACROS_SVH

// same-cycle implication
`define XES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/xes_pkg.sv */
// ----------------------------------------------------------------------------
// Encoding sniffer package
// Parser phases, encoding codes, byte constants and the value classifier.
// ----------------------------------------------------------------------------
package xes_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_KEYWORD = 3'd1,
        PH_QUOTE   = 3'd2,
        PH_VALUE   = 3'd3,
        PH_DROP    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ENC_UTF8        = 3'd0,
        ENC_GB18030     = 3'd1,
        ENC_GB2312      = 3'd2,
        ENC_BIG5        = 3'd3,
        ENC_UNSUPPORTED = 3'd4
    } t_enc;

    typedef struct packed {
        logic valid;
        t_enc code;
    } t_result;

    localparam int LEAD_LEN    = 5;
    localparam int KEY_LEN     = 9;
    localparam int VALUE_SLOTS = 7;
    localparam int VALUE_SAT   = 8;

    typedef logic [VALUE_SLOTS-1:0][7:0] t_chars;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_E      = 8'h65;

    // "<?xml" one byte at a time
    function automatic logic [7:0] lead_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = "<";
            3'd1:    b = "?";
            3'd2:    b = "x";
            3'd3:    b = "m";
            3'd4:    b = "l";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // "encoding=" one byte at a time
    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = "e";
            4'd1:    b = "n";
            4'd2:    b = "c";
            4'd3:    b = "o";
            4'd4:    b = "d";
            4'd5:    b = "i";
            4'd6:    b = "n";
            4'd7:    b = "g";
            4'd8:    b = "=";
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // case-blind match of the stored value against the known names
    function automatic t_enc classify(input t_chars c, input logic [3:0] len);
        t_chars f;
        t_enc   e;
        for (int i = 0; i < VALUE_SLOTS; i++) begin
            f[i] = fold_upper(c[i]);
        end
        e = ENC_UNSUPPORTED;
        case (len)
            4'd7: if ({f[0], f[1], f[2], f[3], f[4], f[5], f[6]} == "GB18030")
                      e = ENC_GB18030;
            4'd6: if ({f[0], f[1], f[2], f[3], f[4], f[5]} == "GB2312")
                      e = ENC_GB2312;
            4'd5: if ({f[0], f[1], f[2], f[3], f[4]} == "UTF-8")
                      e = ENC_UTF8;
            4'd4: if ({f[0], f[1], f[2], f[3]} == "BIG5")
                      e = ENC_BIG5;
            4'd3: if ({f[0], f[1], f[2]} == "GBK")
                      e = ENC_GB18030;
            default: e = ENC_UNSUPPORTED;
        endcase
        return e;
    endfunction

endpackage

/* hdl/xes_parser.sv */
// ----------------------------------------------------------------------------
// Encoding sniffer parser
// Per-beat state machine: prefix check, keyword search, quoted value capture.
// ----------------------------------------------------------------------------
module xes_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte_value,
    input  logic             i_is_last,
    output xes_pkg::t_result o_res
);

    xes_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_prefix_count, n_prefix_count;
    logic [3:0]      r_keyword_progress, n_keyword_progress;
    logic            r_quote_is_double, n_quote_is_double;
    logic [3:0]      r_value_length, n_value_length;
    xes_pkg::t_chars r_value_chars;

    logic          decided;
    xes_pkg::t_enc code;
    logic          wr_en;
    logic [7:0]    close_ch;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= xes_pkg::PH_PREFIX;
            r_prefix_count     <= '0;
            r_keyword_progress <= '0;
            r_quote_is_double  <= 1'b0;
            r_value_length     <= '0;
        end else begin
            r_phase            <= n_phase;
            r_prefix_count     <= n_prefix_count;
            r_keyword_progress <= n_keyword_progress;
            r_quote_is_double  <= n_quote_is_double;
            r_value_length     <= n_value_length;
        end
    end

    // value byte store, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_value_chars[r_value_length[2:0]] <= i_byte_value;
        end
    end

    assign close_ch = r_quote_is_double ? xes_pkg::CH_DQUOTE : xes_pkg::CH_SQUOTE;

    // next state and result
    always_comb begin
        n_phase            = r_phase;
        n_prefix_count     = r_prefix_count;
        n_keyword_progress = r_keyword_progress;
        n_quote_is_double  = r_quote_is_double;
        n_value_length     = r_value_length;
        decided            = 1'b0;
        code               = xes_pkg::ENC_UTF8;
        wr_en              = 1'b0;
        if (i_fire) begin
            unique case (r_phase)
                xes_pkg::PH_PREFIX: begin
                    if (r_prefix_count < 3'(xes_pkg::LEAD_LEN) &&
                        i_byte_value == xes_pkg::lead_byte(r_prefix_count)) begin
                        n_prefix_count = r_prefix_count + 3'd1;
                        if (r_prefix_count == 3'(xes_pkg::LEAD_LEN - 1)) begin
                            n_phase = xes_pkg::PH_KEYWORD;
                        end
                    end else begin
                        decided = 1'b1;
                    end
                end
                xes_pkg::PH_KEYWORD: begin
                    if (i_byte_value == xes_pkg::CH_QMARK || i_byte_value == xes_pkg::CH_GT) begin
                        decided = 1'b1;
                    end else if (r_keyword_progress < 4'(xes_pkg::KEY_LEN) &&
                                 i_byte_value == xes_pkg::key_byte(r_keyword_progress)) begin
                        n_keyword_progress = r_keyword_progress + 4'd1;
                        if (r_keyword_progress == 4'(xes_pkg::KEY_LEN - 1)) begin
                            n_phase = xes_pkg::PH_QUOTE;
                        end
                    end else begin
                        // restart, counting a fresh 'e'
                        n_keyword_progress = (i_byte_value == xes_pkg::CH_E) ? 4'd1 : 4'd0;
                    end
                end
                xes_pkg::PH_QUOTE: begin
                    if (i_byte_value == xes_pkg::CH_DQUOTE ||
                        i_byte_value == xes_pkg::CH_SQUOTE) begin
                        n_quote_is_double = (i_byte_value == xes_pkg::CH_DQUOTE);
                        n_value_length    = '0;
                        n_phase           = xes_pkg::PH_VALUE;
                    end else begin
                        decided = 1'b1;
                    end
                end
                xes_pkg::PH_VALUE: begin
                    if (i_byte_value == close_ch) begin
                        code    = xes_pkg::classify(r_value_chars, r_value_length);
                        decided = 1'b1;
                    end else begin
                        wr_en = (r_value_length < 4'(xes_pkg::VALUE_SLOTS));
                        if (r_value_length < 4'(xes_pkg::VALUE_SAT)) begin
                            n_value_length = r_value_length + 4'd1;
                        end
                    end
                end
                xes_pkg::PH_DROP: begin
                end
                default: begin
                end
            endcase

            // end of document before a decision
            if (!decided && i_is_last && r_phase != xes_pkg::PH_DROP) begin
                decided = 1'b1;
                code    = xes_pkg::ENC_UTF8;
            end

            if (i_is_last) begin
                n_phase            = xes_pkg::PH_PREFIX;
                n_prefix_count     = '0;
                n_keyword_progress = '0;
                n_quote_is_double  = 1'b0;
                n_value_length     = '0;
            end else if (decided) begin
                n_phase = xes_pkg::PH_DROP;
            end
        end
    end

    assign o_res.valid = decided;
    assign o_res.code  = code;

endmodule

/* hdl/xes_out_buf.sv */
// ----------------------------------------------------------------------------
// Encoding sniffer output buffer
// Result register with a skid stage; stalls the input only when the skid is full.
// ----------------------------------------------------------------------------
module xes_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  xes_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_encoding,
    output logic             o_full
);

    logic          r_out_v, r_skid_v;
    xes_pkg::t_enc r_out_d, r_skid_d;
    logic          pop;

    assign pop = r_out_v && !i_stall;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v) begin
                r_out_v <= i_res.valid;
            end else if (pop) begin
                if (r_skid_v) begin
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= i_res.valid;
                end
            end else if (i_res.valid) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            r_out_d <= r_skid_v ? r_skid_d : i_res.code;
        end
        if (r_out_v && !pop && i_res.valid) begin
            r_skid_d <= i_res.code;
        end
    end

    assign o_valid    = r_out_v;
    assign o_encoding = r_out_d;
    assign o_full     = r_skid_v;

endmodule

/* hdl/xml_encoding_sniffer.sv */
// A result beat is registered in the output buffer (or its skid stage) from the byte that decides it.
// Throughput: one byte per cycle while o_stall is low; the parser state updates in the accept cycle.
// A skid stage keeps input flowing while one result waits downstream.
// Reset (synchronous, active low) returns the parser to the prefix phase and
// empties the output buffer; the value byte store is not cleared.
// ----------------------------------------------------------------------------
// XML encoding sniffer
// Reads a document byte stream and reports its declared encoding once.
// ----------------------------------------------------------------------------
`include "xml_encoding_sniffer_macros.svh"

module xml_encoding_sniffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_value,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_encoding
);

    xes_pkg::t_result res;
    logic             fire;

    assign fire = i_valid && !o_stall;

    xes_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte_value (i_byte_value),
        .i_is_last    (i_is_last),
        .o_res        (res)
    );

    xes_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_encoding (o_encoding),
        .o_full     (o_stall)
    );

    // skid in use only behind a held result
    `XES_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, o_stall, o_valid, "skid without result")
    // no result is produced while the skid is full
    `XES_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, res.valid, !o_stall, "result lost")
    // a result behind a stalled one lands in the skid
    `XES_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, res.valid && o_valid && i_stall,
        o_stall, "skid not filled")

endmodule

/* test/tb_xml_encoding_sniffer.sv */
// ----------------------------------------------------------------------------
// Testbench for the XML encoding sniffer
// Feeds whole documents byte by byte: a few hand-picked ones, then mostly
// well-formed declarations with random content, mixed with broken ones and
// noise. Each accepted byte goes through a local model of the sniffer. Each
// encoding beat that comes out is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_xml_encoding_sniffer;

    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_PCT     = 13;
    localparam int HOLD_START   = 200;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [39:0] LEAD_SEQ = "<?xml";
    localparam logic [71:0] KEY_SEQ  = "encoding=";
    localparam logic [7:0]  CH_DQ    = 8'h22;
    localparam logic [7:0]  CH_SQ    = 8'h27;
    localparam logic [7:0]  CH_QM    = 8'h3F;
    localparam logic [7:0]  CH_GT    = 8'h3E;
    localparam logic [7:0]  CH_LOW_E = 8'h65;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_doc_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_is_last = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_encoding;

    xml_encoding_sniffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_byte_value(i_byte_value),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_encoding  (o_encoding)
    );

    // document bytes waiting to be offered, and predicted encodings
    t_doc_beat      byte_queue[$];
    xes_pkg::t_enc  enc_expected[$];
    logic [7:0]     doc_bytes[$];
    int             total_beats = 0;
    int             beats_accepted = 0;
    int             fault_count = 0;

    // parser state of the local model
    xes_pkg::t_phase sn_phase = xes_pkg::PH_PREFIX;
    logic [2:0]      sn_lead = '0;
    logic [3:0]      sn_key = '0;
    logic            sn_dq = 1'b0;
    logic [7:0]      sn_chars[7];
    logic [3:0]      sn_len = '0;

    // ------------------------------------------------------------------
    // Model of the sniffer
    // ------------------------------------------------------------------
    function automatic logic [7:0] upcase_ascii(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    // case-blind match of the stored value against the supported names
    function automatic xes_pkg::t_enc encoding_of_value();
        logic [55:0]   word;
        xes_pkg::t_enc code;
        word = '0;
        code = xes_pkg::ENC_UNSUPPORTED;
        if (sn_len <= 4'd7) begin
            for (int i = 0; i < int'(sn_len); i++) begin
                word = {word[47:0], upcase_ascii(sn_chars[i])};
            end
        end
        case (sn_len)
            4'd7: if (word == 56'("GB18030")) code = xes_pkg::ENC_GB18030;
            4'd6: if (word == 56'("GB2312"))  code = xes_pkg::ENC_GB2312;
            4'd5: if (word == 56'("UTF-8"))   code = xes_pkg::ENC_UTF8;
            4'd4: if (word == 56'("BIG5"))    code = xes_pkg::ENC_BIG5;
            4'd3: if (word == 56'("GBK"))     code = xes_pkg::ENC_GB18030;
            default: code = xes_pkg::ENC_UNSUPPORTED;
        endcase
        return code;
    endfunction

    function automatic void restart_doc();
        sn_phase = xes_pkg::PH_PREFIX;
        sn_lead  = '0;
        sn_key   = '0;
        sn_dq    = 1'b0;
        sn_len   = '0;
    endfunction

    // advance the model by one accepted byte; queue the encoding if decided
    function automatic void sniff_byte(input logic [7:0] b, input logic last);
        logic          decided;
        xes_pkg::t_enc code;
        decided = 1'b0;
        code    = xes_pkg::ENC_UTF8;
        case (sn_phase)
            xes_pkg::PH_PREFIX: begin
                if (sn_lead < 3'd5 && b == LEAD_SEQ[8*(4-int'(sn_lead)) +: 8]) begin
                    sn_lead = sn_lead + 3'd1;
                    if (sn_lead == 3'd5) sn_phase = xes_pkg::PH_KEYWORD;
                end else begin
                    decided = 1'b1;
                end
            end
            xes_pkg::PH_KEYWORD: begin
                if (b == CH_QM || b == CH_GT) begin
                    decided = 1'b1;
                end else if (sn_key < 4'd9 && b == KEY_SEQ[8*(8-int'(sn_key)) +: 8]) begin
                    sn_key = sn_key + 4'd1;
                    if (sn_key == 4'd9) sn_phase = xes_pkg::PH_QUOTE;
                end else begin
                    // a stray 'e' may itself open the keyword
                    sn_key = (b == CH_LOW_E) ? 4'd1 : 4'd0;
                end
            end
            xes_pkg::PH_QUOTE: begin
                if (b == CH_DQ || b == CH_SQ) begin
                    sn_dq    = (b == CH_DQ);
                    sn_len   = '0;
                    sn_phase = xes_pkg::PH_VALUE;
                end else begin
                    decided = 1'b1;
                end
            end
            xes_pkg::PH_VALUE: begin
                if (b == (sn_dq ? CH_DQ : CH_SQ)) begin
                    code    = encoding_of_value();
                    decided = 1'b1;
                end else begin
                    if (sn_len < 4'd7) sn_chars[sn_len[2:0]] = b;
                    if (sn_len < 4'd8) sn_len = sn_len + 4'd1;
                end
            end
            default: ;
        endcase

        // document ended before any decision
        if (!decided && last && sn_phase != xes_pkg::PH_DROP) begin
            decided = 1'b1;
            code    = xes_pkg::ENC_UTF8;
        end

        if (decided) begin
            enc_expected.push_back(code);
            if (last) restart_doc();
            else sn_phase = xes_pkg::PH_DROP;
        end else if (last) begin
            restart_doc();
        end
    endfunction

    // ------------------------------------------------------------------
    // Document builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_case(input logic [7:0] c);
        if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
                && $urandom_range(1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] q);
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == q);
        return c;
    endfunction

    function automatic string pick_name();
        case ($urandom_range(5))
            0: return "UTF-8";
            1: return "GB18030";
            2: return "GB2312";
            3: return "BIG5";
            4: return "GBK";
            default: return "GB10830";
        endcase
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
    endfunction

    function automatic void add_cased(input string s);
        for (int i = 0; i < s.len(); i++) doc_bytes.push_back(any_case(s[i]));
    endfunction

    // declared value between the quotes; q is the closing quote
    function automatic void add_value(input logic [7:0] q);
        string      s;
        int         k;
        int         n;
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: add_cased(pick_name());
            6: begin
                // one character spoilt
                s = pick_name();
                k = $urandom_range(s.len() - 1);
                for (int i = 0; i < s.len(); i++) begin
                    if (i == k) begin
                        do c = 8'($urandom_range(32, 126)); while (c == q);
                        doc_bytes.push_back(c);
                    end else begin
                        doc_bytes.push_back(any_case(s[i]));
                    end
                end
            end
            7: begin
                n = $urandom_range(10);
                for (int i = 0; i < n; i++) doc_bytes.push_back(byte_other_than(q));
            end
            8: begin
                n = $urandom_range(2);
                for (int i = 0; i < n; i++) doc_bytes.push_back(byte_other_than(q));
            end
            default: begin
                add_cased(pick_name());
                doc_bytes.push_back(byte_other_than(q));
            end
        endcase
    endfunction

    // text between the prefix and the keyword
    function automatic void add_filler();
        int         n;
        logic [7:0] c;
        n = $urandom_range(3);
        for (int seg = 0; seg < n; seg++) begin
            case ($urandom_range(4))
                0: add_text(" v='1'");
                1: add_text(" ");
                2: begin
                    // keyword cut short, so the search restarts
                    for (int i = 0; i < $urandom_range(1, 8); i++) begin
                        doc_bytes.push_back(KEY_SEQ[8*(8-i) +: 8]);
                    end
                end
                3: begin
                    for (int i = 0; i < $urandom_range(1, 3); i++) begin
                        doc_bytes.push_back(any_case(8'($urandom_range(8'h61, 8'h7A))));
                    end
                end
                default: begin
                    do c = 8'($urandom_range(255)); while (c == CH_QM || c == CH_GT);
                    doc_bytes.push_back(c);
                end
            endcase
        end
    endfunction

    function automatic void add_tail();
        for (int i = 0; i < $urandom_range(4); i++) begin
            doc_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    // move the first keep bytes of the built document to the byte queue
    function automatic void emit_doc(input int keep);
        t_doc_beat bt;
        for (int i = 0; i < keep; i++) begin
            bt.value = doc_bytes[i];
            bt.last  = (i == keep - 1);
            byte_queue.push_back(bt);
        end
        doc_bytes.delete();
    endfunction

    function automatic void build_declared_doc();
        logic [7:0] q;
        add_text("<?xml");
        add_filler();
        add_text("encoding=");
        q = ($urandom_range(1) == 1) ? CH_DQ : CH_SQ;
        doc_bytes.push_back(q);
        add_value(q);
        doc_bytes.push_back(q);
        add_tail();
        // some documents end early, anywhere
        if ($urandom_range(99) < 12) emit_doc($urandom_range(1, doc_bytes.size()));
        else emit_doc(doc_bytes.size());
    endfunction

    function automatic void build_broken_doc();
        int k;
        case ($urandom_range(2))
            0: begin
                k = $urandom_range(4);
                for (int i = 0; i < k; i++) doc_bytes.push_back(LEAD_SEQ[8*(4-i) +: 8]);
                doc_bytes.push_back(8'($urandom_range(255)));
            end
            1: begin
                add_text("<?xml");
                add_filler();
                doc_bytes.push_back(($urandom_range(1) == 1) ? CH_QM : CH_GT);
            end
            default: begin
                add_text("<?xml");
                add_filler();
                add_text("encoding=");
                doc_bytes.push_back(byte_other_than(($urandom_range(1) == 1) ? CH_DQ : CH_SQ));
            end
        endcase
        add_tail();
        emit_doc(doc_bytes.size());
    endfunction

    function automatic void build_noise_doc();
        for (int i = 0; i < $urandom_range(1, 8); i++) begin
            doc_bytes.push_back(8'($urandom_range(255)));
        end
        emit_doc(doc_bytes.size());
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, idling now and then
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        t_doc_beat nb;
        int        drv_cycle;
        bit        idle;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            drv_cycle = 0;
        end else begin
            drv_cycle++;
            if (i_valid && !o_stall) begin
                sniff_byte(i_byte_value, i_is_last);
                beats_accepted++;
            end
            // a stalled beat stays put; otherwise pick the next one
            if (!i_valid || !o_stall) begin
                idle = (drv_cycle < 150 || drv_cycle >= 450)
                    && $urandom_range(99) < IDLE_PCT;
                if (byte_queue.size() != 0 && !idle) begin
                    nb = byte_queue.pop_front();
                    i_valid      <= 1'b1;
                    i_byte_value <= nb.value;
                    i_is_last    <= nb.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks encoding beats and drives the output stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_encodings
        xes_pkg::t_enc want;
        int            mon_cycle;
        int            hold_left;
        bit            hold_done;
        bit            stall_next;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            mon_cycle = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            mon_cycle++;
            if (o_valid && !i_stall) begin
                if (enc_expected.size() == 0) begin
                    $error("encoding: no beat expected, got %0d", o_encoding);
                    fault_count++;
                end else begin
                    want = enc_expected.pop_front();
                    if (o_encoding !== want) begin
                        $error("encoding: expected %0d, got %0d", want, o_encoding);
                        fault_count++;
                    end
                end
            end

            // one long hold-off so the sniffer backs up onto its input
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && mon_cycle >= HOLD_START) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end else if (mon_cycle >= 600 && mon_cycle < 900) begin
                stall_next = 1'b0;
            end else begin
                stall_next = ($urandom_range(99) < IDLE_PCT);
            end
            i_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat moving on either side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // hand-picked documents: byte extremes, bad prefix with dropped
        // bytes, early end, closing bracket and question mark before the keyword
        doc_bytes.push_back(8'h00);
        emit_doc(1);
        doc_bytes.push_back(8'hFF);
        doc_bytes.push_back(8'h80);
        emit_doc(2);
        add_text("<?");
        emit_doc(2);
        add_text("<?xml>");
        emit_doc(6);
        add_text("<?xml?x");
        emit_doc(7);

        // mostly well-formed declarations, the rest broken or noise
        while (byte_queue.size() < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0, 1, 2:    build_broken_doc();
                3, 4:       build_noise_doc();
                default:    build_declared_doc();
            endcase
        end
        total_beats = byte_queue.size();

        while (!i_rst_n) @(posedge i_clk);
        while (beats_accepted < total_beats) @(posedge i_clk);
        while (enc_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
